// ===== sv/va_pkg.sv =====
// Shared types, constants and saturation helper for the vector ALU.
package va_pkg;

   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_SUB    = 3'd1,
      KIND_SCALE  = 3'd2,
      KIND_DOT    = 3'd3,
      KIND_LENGTH = 3'd4,
      KIND_NORM   = 3'd5,
      KIND_CROSS  = 3'd6,
      KIND_XFORM  = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_ZERO = 2'd2
   } status_type;

   localparam int N_LANES    = 4;
   localparam int N_ELEM     = 3;
   localparam int N_ROWS     = 4;
   localparam int ROW_IDX_W  = $clog2(N_ROWS);
   localparam int CSR_ADDR_W = 8;
   localparam int ROW_W      = 64;
   localparam int COEF_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int MAG_W      = 32;
   localparam int LEN_W      = 33;
   localparam int DIVD_W     = 48;
   localparam int Q_BITS     = 18;
   localparam int SQ_STEPS   = 32;

   localparam int ST_SUM    = 1;
   localparam int ST_LEN    = ST_SUM + SQ_STEPS + 1;
   localparam int ST_DIV_IN = ST_LEN + 1;
   localparam int ST_LAST   = ST_DIV_IN + Q_BITS;
   localparam int NSTG      = ST_LAST + 2;

   localparam logic [Q_BITS-1:0] Q_MAX   = 18'd98304;
   localparam logic [31:0]       MAX_POS = 32'h7fff_ffff;
   localparam logic [31:0]       MAX_NEG = 32'h8000_0000;
   localparam logic signed [65:0] RND16 = 66'sd32768;
   localparam logic signed [65:0] RND8  = 66'sd128;

   localparam logic [ROW_W-1:0] ROW_RESET [N_ROWS] = '{
      64'd256, 64'd16777216, 64'd1099511627776, 64'd72057594037927936
   };

   typedef logic [N_ROWS-1:0][COEF_W-1:0] row_type;
   typedef logic [N_LANES-1:0][31:0]      vec4_type;

   typedef struct packed {
      logic [31:0] val;
      logic        sat;
   } sat_type;

   typedef struct packed {
      kind_type                        kind;
      logic [31:0]                     rx;
      logic [31:0]                     ry;
      logic [31:0]                     rz;
      logic [31:0]                     rw;
      logic [31:0]                     scalar;
      logic                            sat;
      logic [N_ELEM-1:0]               neg;
      logic [N_ELEM-1:0][MAG_W-1:0]    mag;
      logic [LEN_W-1:0]                len;
   } side_type;

   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type o;
      if (v > 66'sd2147483647) begin
         o.val = MAX_POS;
         o.sat = 1'b1;
      end else if (v < -66'sd2147483648) begin
         o.val = MAX_NEG;
         o.sat = 1'b1;
      end else begin
         o.val = v[31:0];
         o.sat = 1'b0;
      end
      return o;
   endfunction

endpackage

// ===== sv/va_ifs.sv =====
// Handshake interfaces for the request, response and register write channels.
interface va_req_if import va_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] a_w;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] scale;

   modport source (output valid, kind, a_x, a_y, a_z, a_w, b_x, b_y, b_z, scale,
                   input ready);
   modport sink (input valid, kind, a_x, a_y, a_z, a_w, b_x, b_y, b_z, scale,
                 output ready);
endinterface

interface va_rsp_if import va_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic signed [31:0] r_w;
   logic signed [31:0] r_scalar;
   logic [1:0]         status;

   modport source (output valid, r_x, r_y, r_z, r_w, r_scalar, status, input ready);
   modport sink (input valid, r_x, r_y, r_z, r_w, r_scalar, status, output ready);
endinterface

interface va_csr_if import va_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [ROW_W-1:0]      wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== sv/va_lane.sv =====
// One element lane: products, then rounded and saturated per-element result.
module va_lane import va_pkg::*; (
   input  logic               clock,
   input  logic [1:0]         en,
   input  kind_type           kind,
   input  logic signed [31:0] a_e,
   input  logic signed [31:0] b_e,
   input  logic signed [31:0] s,
   input  logic signed [31:0] ca0,
   input  logic signed [31:0] cb0,
   input  logic signed [31:0] ca1,
   input  logic signed [31:0] cb1,
   input  row_type            row,
   input  vec4_type           a_vec,
   output logic signed [31:0] r,
   output logic               sat,
   output logic signed [63:0] p0,
   output logic signed [63:0] p1
);

   kind_type           kind_ff;
   logic signed [32:0] sum_ff, sum_in;
   logic signed [63:0] p0_ff, p0_in, p1_ff, p1_in;
   logic signed [47:0] pt_ff [N_LANES];
   logic signed [47:0] pt_in [N_LANES];
   logic [31:0]        r_ff;
   logic               sat_ff;
   logic signed [31:0] m0a, m0b, m1a, m1b;
   logic signed [65:0] v, xs;
   sat_type            sv;

   always_comb begin
      unique case (kind)
         KIND_SCALE: begin
            m0a = a_e;
            m0b = s;
         end
         KIND_CROSS: begin
            m0a = ca0;
            m0b = cb0;
         end
         default: begin
            m0a = a_e;
            m0b = b_e;
         end
      endcase
      if (kind == KIND_CROSS) begin
         m1a = ca1;
         m1b = cb1;
      end else begin
         m1a = a_e;
         m1b = a_e;
      end
      sum_in = (kind == KIND_SUB) ? (33'(a_e) - 33'(b_e)) : (33'(a_e) + 33'(b_e));
      p0_in  = 64'(m0a) * 64'(m0b);
      p1_in  = 64'(m1a) * 64'(m1b);
      for (int c = 0; c < N_LANES; c++) begin
         pt_in[c] = 48'($signed(row[c])) * 48'($signed(a_vec[c]));
      end
   end

   always_comb begin
      xs = 66'(pt_ff[0]) + 66'(pt_ff[1]) + 66'(pt_ff[2]) + 66'(pt_ff[3]);
      unique case (kind_ff)
         KIND_ADD, KIND_SUB: v = 66'(sum_ff);
         KIND_SCALE:         v = (66'(p0_ff) + RND16) >>> 16;
         KIND_CROSS:         v = (66'(p0_ff) - 66'(p1_ff) + RND16) >>> 16;
         KIND_XFORM:         v = (xs + RND8) >>> 8;
         default:            v = '0;
      endcase
      sv = sat32(v);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         kind_ff <= kind;
         sum_ff  <= sum_in;
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         for (int c = 0; c < N_LANES; c++) begin
            pt_ff[c] <= pt_in[c];
         end
      end
      if (en[1]) begin
         r_ff   <= sv.val;
         sat_ff <= sv.sat;
      end
   end

   assign r   = $signed(r_ff);
   assign sat = sat_ff;
   assign p0  = p0_ff;
   assign p1  = p1_ff;

endmodule

// ===== sv/va_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module va_sqrt import va_pkg::*; (
   input  logic                  clock,
   input  logic [SQ_STEPS+1:0]   en,
   input  logic [63:0]           s,
   output logic [LEN_W-1:0]      len
);

   logic [63:0]      x_ff   [SQ_STEPS+1];
   logic [63:0]      res_ff [SQ_STEPS+1];
   logic [63:0]      x_in   [SQ_STEPS+1];
   logic [63:0]      res_in [SQ_STEPS+1];
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;

   always_comb begin
      logic [63:0] bitv;
      logic [64:0] t;
      x_in[0]   = s;
      res_in[0] = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
         bitv = 64'(1) << (62 - 2 * k);
         t    = {1'b0, res_ff[k]} + {1'b0, bitv};
         if ({1'b0, x_ff[k]} >= t) begin
            x_in[k+1]   = x_ff[k] - t[63:0];
            res_in[k+1] = (res_ff[k] >> 1) + bitv;
         end else begin
            x_in[k+1]   = x_ff[k];
            res_in[k+1] = res_ff[k] >> 1;
         end
      end
      len_in = res_ff[SQ_STEPS][LEN_W-1:0]
             + LEN_W'(x_ff[SQ_STEPS] > res_ff[SQ_STEPS]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
         if (en[k]) begin
            x_ff[k]   <= x_in[k];
            res_ff[k] <= res_in[k];
         end
      end
      if (en[SQ_STEPS+1]) begin
         len_ff <= len_in;
      end
   end

   assign len = len_ff;

endmodule

// ===== sv/va_div.sv =====
// Pipelined restoring divider for one normalize lane, one quotient bit per stage.
module va_div import va_pkg::*; (
   input  logic                 clock,
   input  logic [Q_BITS:0]      en,
   input  logic [MAG_W-1:0]     mag,
   input  logic [LEN_W-1:0]     len,
   output logic [Q_BITS-1:0]    q
);

   localparam int CMP_W = LEN_W + Q_BITS;

   logic [DIVD_W-1:0] m_ff [Q_BITS+1];
   logic [DIVD_W-1:0] m_in [Q_BITS+1];
   logic [LEN_W-1:0]  d_ff [Q_BITS+1];
   logic [LEN_W-1:0]  d_in [Q_BITS+1];
   logic [Q_BITS-1:0] q_ff [Q_BITS+1];
   logic [Q_BITS-1:0] q_in [Q_BITS+1];

   always_comb begin
      logic [CMP_W-1:0] ds;
      m_in[0] = {mag, {FRAC_W{1'b0}}} + DIVD_W'(len >> 1);
      d_in[0] = len;
      q_in[0] = '0;
      for (int k = 0; k < Q_BITS; k++) begin
         ds = CMP_W'(d_ff[k]) << (Q_BITS - 1 - k);
         d_in[k+1] = d_ff[k];
         if (CMP_W'(m_ff[k]) >= ds) begin
            m_in[k+1] = m_ff[k] - ds[DIVD_W-1:0];
            q_in[k+1] = q_ff[k] | (Q_BITS'(1) << (Q_BITS - 1 - k));
         end else begin
            m_in[k+1] = m_ff[k];
            q_in[k+1] = q_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= Q_BITS; k++) begin
         if (en[k]) begin
            m_ff[k] <= m_in[k];
            d_ff[k] <= d_in[k];
            q_ff[k] <= q_in[k];
         end
      end
   end

   assign q = q_ff[Q_BITS];

endmodule

// ===== sv/vec4_vector_alu.sv =====
// Fixed-point vector ALU top level: four element lanes, length and normalize units, merge.
// Usage: each transaction on req_bus carries an operation kind, vector A (x,y,z,w),
// vector B (x,y,z) and a scale factor, all signed Q16.16. Exactly one transaction
// leaves on rsp_bus for each one accepted, in order, with r_x..r_w, r_scalar and
// a two-bit status (ok, saturated, normalize of a zero vector).
// csr_bus writes the four 64-bit matrix rows (Q8.8 coefficients) used by the
// transform; it is always ready, and writes to an index above three are dropped.
// Write the matrix only while no transaction is in flight.
// Every kind takes the same path from the accepting edge to rsp_bus.valid, through
// the 32-step square root followed by the 18-step divider that the length and
// normalize kinds share with the rest of the pipeline.
// Throughput is one transaction per cycle while rsp_bus.ready stays high.
// When rsp_bus.ready is low, the result waits in the output register and the
// pipeline keeps accepting until every stage is full; req_bus.ready then drops.
// Reset clears all stage valid bits and loads the identity matrix.
module vec4_vector_alu import va_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   va_req_if.sink     req_bus,
   va_rsp_if.source   rsp_bus,
   va_csr_if.sink     csr_bus
);

   typedef struct packed {
      logic [31:0] rx;
      logic [31:0] ry;
      logic [31:0] rz;
      logic [31:0] rw;
      logic [31:0] scalar;
      status_type  status;
   } rsp_type;

   row_type            matrix_ff [N_ROWS];
   logic [NSTG-1:0]    v_ff;
   logic [NSTG-1:0]    rdy;
   side_type           side_ff [ST_LAST+1];
   side_type           side_in [ST_LAST+1];
   rsp_type            out_ff, out_in;

   logic signed [31:0] a_arr [N_ELEM];
   logic signed [31:0] b_arr [N_ELEM];
   vec4_type           a_vec;
   logic signed [31:0] lane_r   [N_LANES];
   logic               lane_sat [N_LANES];
   logic signed [63:0] lane_p0  [N_LANES];
   logic signed [63:0] lane_p1  [N_LANES];
   logic signed [65:0] dot_v;
   sat_type            dot_s;
   logic [63:0]        sumsq;
   logic [LEN_W-1:0]   sq_len;
   logic [Q_BITS-1:0]  div_q [N_ELEM];
   side_type           sd;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_ROWS; i++) begin
            matrix_ff[i] <= ROW_RESET[i];
         end
      end else if (csr_bus.valid && (csr_bus.addr < CSR_ADDR_W'(N_ROWS))) begin
         matrix_ff[csr_bus.addr[ROW_IDX_W-1:0]] <= csr_bus.wdata;
      end
   end

   always_comb begin
      rdy[NSTG-1] = !v_ff[NSTG-1] || rsp_bus.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign req_bus.ready = rdy[0];
   assign rsp_bus.valid = v_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign a_arr[0] = req_bus.a_x;
   assign a_arr[1] = req_bus.a_y;
   assign a_arr[2] = req_bus.a_z;
   assign b_arr[0] = req_bus.b_x;
   assign b_arr[1] = req_bus.b_y;
   assign b_arr[2] = req_bus.b_z;
   assign a_vec    = {req_bus.a_w, req_bus.a_z, req_bus.a_y, req_bus.a_x};

   for (genvar g = 0; g < N_ELEM; g++) begin : g_lane
      va_lane u_lane (
         .clock (clock),
         .en    (rdy[ST_SUM:0]),
         .kind  (kind_type'(req_bus.kind)),
         .a_e   (a_arr[g]),
         .b_e   (b_arr[g]),
         .s     (req_bus.scale),
         .ca0   (a_arr[(g + 1) % N_ELEM]),
         .cb0   (b_arr[(g + 2) % N_ELEM]),
         .ca1   (a_arr[(g + 2) % N_ELEM]),
         .cb1   (b_arr[(g + 1) % N_ELEM]),
         .row   (matrix_ff[g]),
         .a_vec (a_vec),
         .r     (lane_r[g]),
         .sat   (lane_sat[g]),
         .p0    (lane_p0[g]),
         .p1    (lane_p1[g])
      );
   end

   va_lane u_lane_w (
      .clock (clock),
      .en    (rdy[ST_SUM:0]),
      .kind  (kind_type'(req_bus.kind)),
      .a_e   (req_bus.a_w),
      .b_e   (32'sd0),
      .s     (req_bus.scale),
      .ca0   (32'sd0),
      .cb0   (32'sd0),
      .ca1   (32'sd0),
      .cb1   (32'sd0),
      .row   (matrix_ff[N_ROWS-1]),
      .a_vec (a_vec),
      .r     (lane_r[N_LANES-1]),
      .sat   (lane_sat[N_LANES-1]),
      .p0    (lane_p0[N_LANES-1]),
      .p1    (lane_p1[N_LANES-1])
   );

   always_comb begin
      dot_v = (66'(lane_p0[0]) + 66'(lane_p0[1]) + 66'(lane_p0[2]) + RND16) >>> 16;
      dot_s = sat32(dot_v);
      sumsq = $unsigned(lane_p1[0]) + $unsigned(lane_p1[1]) + $unsigned(lane_p1[2]);
   end

   va_sqrt u_sqrt (
      .clock (clock),
      .en    (rdy[ST_LEN:ST_SUM]),
      .s     (sumsq),
      .len   (sq_len)
   );

   for (genvar g = 0; g < N_ELEM; g++) begin : g_div
      va_div u_div (
         .clock (clock),
         .en    (rdy[ST_LAST:ST_DIV_IN]),
         .mag   (side_ff[ST_LEN].mag[g]),
         .len   (sq_len),
         .q     (div_q[g])
      );
   end

   always_comb begin
      side_in[0]      = '0;
      side_in[0].kind = kind_type'(req_bus.kind);
      side_in[0].rw   = req_bus.a_w;
      for (int e = 0; e < N_ELEM; e++) begin
         side_in[0].neg[e] = a_arr[e][31];
         side_in[0].mag[e] = a_arr[e][31] ? (~a_arr[e] + 32'd1) : a_arr[e];
      end
      for (int i = 1; i <= ST_LAST; i++) begin
         side_in[i] = side_ff[i-1];
      end

      if (side_ff[0].kind == KIND_DOT) begin
         side_in[ST_SUM].scalar = dot_s.val;
         side_in[ST_SUM].sat    = dot_s.sat;
      end

      side_in[ST_SUM+1].rx  = lane_r[0];
      side_in[ST_SUM+1].ry  = lane_r[1];
      side_in[ST_SUM+1].rz  = lane_r[2];
      side_in[ST_SUM+1].sat = side_ff[ST_SUM].sat || lane_sat[0] || lane_sat[1]
                           || lane_sat[2]
                           || ((side_ff[ST_SUM].kind == KIND_XFORM) && lane_sat[N_LANES-1]);
      if (side_ff[ST_SUM].kind == KIND_XFORM) begin
         side_in[ST_SUM+1].rw = lane_r[N_LANES-1];
      end

      side_in[ST_DIV_IN].len = sq_len;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= ST_LAST; i++) begin
         if (rdy[i]) begin
            side_ff[i] <= side_in[i];
         end
      end
      if (rdy[NSTG-1]) begin
         out_ff <= out_in;
      end
   end

   assign sd = side_ff[ST_LAST];

   always_comb begin
      logic [31:0] qx [N_ELEM];
      out_in.rw     = sd.rw;
      out_in.rx     = sd.rx;
      out_in.ry     = sd.ry;
      out_in.rz     = sd.rz;
      out_in.scalar = '0;
      out_in.status = sd.sat ? STAT_SAT : STAT_OK;
      for (int e = 0; e < N_ELEM; e++) begin
         qx[e] = sd.neg[e] ? (32'd0 - 32'(div_q[e])) : 32'(div_q[e]);
      end
      unique case (sd.kind)
         KIND_DOT: begin
            out_in.rx     = '0;
            out_in.ry     = '0;
            out_in.rz     = '0;
            out_in.scalar = sd.scalar;
         end
         KIND_LENGTH: begin
            out_in.rx = '0;
            out_in.ry = '0;
            out_in.rz = '0;
            if (sd.len > LEN_W'(MAX_POS)) begin
               out_in.scalar = MAX_POS;
               out_in.status = STAT_SAT;
            end else begin
               out_in.scalar = sd.len[31:0];
            end
         end
         KIND_NORM: begin
            if (sd.len == '0) begin
               out_in.rx     = '0;
               out_in.ry     = '0;
               out_in.rz     = '0;
               out_in.status = STAT_ZERO;
            end else begin
               out_in.rx     = qx[0];
               out_in.ry     = qx[1];
               out_in.rz     = qx[2];
               out_in.status = STAT_OK;
            end
         end
         default: begin
            out_in.scalar = '0;
         end
      endcase
   end

   assign rsp_bus.r_x      = $signed(out_ff.rx);
   assign rsp_bus.r_y      = $signed(out_ff.ry);
   assign rsp_bus.r_z      = $signed(out_ff.rz);
   assign rsp_bus.r_w      = $signed(out_ff.rw);
   assign rsp_bus.r_scalar = $signed(out_ff.scalar);
   assign rsp_bus.status   = out_ff.status;

   a_zero_norm_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == STAT_ZERO)) |->
      (rsp_bus.r_x == 32'sd0 && rsp_bus.r_y == 32'sd0 && rsp_bus.r_z == 32'sd0
       && rsp_bus.r_scalar == 32'sd0))
      else $error("Zero-vector normalize produced a nonzero result.");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> v_ff[0])
      else $error("Accepted transaction did not enter the first stage.");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_LAST] && (sd.kind == KIND_NORM) && (sd.len != '0)) |->
      (div_q[0] <= Q_MAX && div_q[1] <= Q_MAX && div_q[2] <= Q_MAX))
      else $error("Normalize quotient exceeded its bound.");

endmodule
